@@ rtl/core/nfss_pkg.sv @@
// ----------------------------------------------------------------------------
// nfss_pkg
// Shared types and constants of the node free-space streak unit.
// ----------------------------------------------------------------------------
package nfss_pkg;

    localparam int DEPTH_W    = 16;
    localparam int ID_W       = 16;
    localparam int STREAK_W   = 16;
    localparam int EPOCH_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int NEIGHBOURS = 9;
    // scaled limit: node_depth * (65536 + tolerance) fits in 33 bits
    localparam int LIMIT_W    = 33;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STREAK_W-1:0] STREAK_MAX    = 16'hFFFF;
    localparam logic [STREAK_W-1:0] DELETE_STREAK = 16'd3;
    localparam logic [DEPTH_W-1:0]  TOL_RESET     = 16'd1311;
    localparam logic [COUNT_W-1:0]  SUPPORT_RESET = 4'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOLERANCE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT_REQUIRED = 1'b1;

    // command codes
    localparam logic CMD_FRAME_TICK = 1'b0;
    localparam logic CMD_NODE       = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    node_id;
        logic [DEPTH_W-1:0] node_depth;
        logic [DEPTH_W-1:0] depth_nw;
        logic [DEPTH_W-1:0] depth_n;
        logic [DEPTH_W-1:0] depth_ne;
        logic [DEPTH_W-1:0] depth_w;
        logic [DEPTH_W-1:0] depth_c;
        logic [DEPTH_W-1:0] depth_e;
        logic [DEPTH_W-1:0] depth_sw;
        logic [DEPTH_W-1:0] depth_s;
        logic [DEPTH_W-1:0] depth_se;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]     out_node_id;
        logic                is_free;
        logic [COUNT_W-1:0]  support_count;
        logic [STREAK_W-1:0] streak_len;
        logic                prune_ready;
    } result_t;

    // merged verdict of the lanes
    typedef struct packed {
        logic               is_free;
        logic [COUNT_W-1:0] support_count;
    } verdict_t;

endpackage

@@ rtl/core/nfss_ram.sv @@
// ----------------------------------------------------------------------------
// nfss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nfss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/nfss_lane.sv @@
// ----------------------------------------------------------------------------
// nfss_lane
// One neighbour lane: votes when the observed depth lies clearly behind the node.
// ----------------------------------------------------------------------------
module nfss_lane (
    input  logic [nfss_pkg::DEPTH_W-1:0] depth,
    input  logic [nfss_pkg::LIMIT_W-1:0] limit,
    output logic                         vote
);

    import nfss_pkg::*;

    logic [LIMIT_W-1:0] depth_scaled;

    // depth * 65536 against node_depth * (65536 + tolerance), exact
    assign depth_scaled = {1'b0, depth, 16'h0000};
    assign vote = (depth != '0) && (depth_scaled > limit);

endmodule

@@ rtl/core/nfss_merge.sv @@
// ----------------------------------------------------------------------------
// nfss_merge
// Merging stage: counts the lane votes and decides whether the node is free.
// ----------------------------------------------------------------------------
module nfss_merge (
    input  logic [nfss_pkg::NEIGHBOURS-1:0] votes,
    input  logic [nfss_pkg::COUNT_W-1:0]    support_required,
    output nfss_pkg::verdict_t              verdict
);

    import nfss_pkg::*;

    logic [COUNT_W-1:0] count;

    // population count of the votes
    always_comb
    begin
        count = '0;
        for (int k = 0; k < NEIGHBOURS; k++)
        begin
            count = count + COUNT_W'(votes[k]);
        end
    end

    assign verdict.support_count = count;
    assign verdict.is_free       = (count >= support_required);

endmodule

@@ rtl/core/node_free_space_streak_unit.sv @@
// ----------------------------------------------------------------------------
// node_free_space_streak_unit
// Free-space evidence and per-node free streak tracker for map nodes.
// ----------------------------------------------------------------------------
// A frame tick (cmd 0) is taken while the unit is idle and advances the
// epoch; busy stays low, so ticks may follow each other every cycle. A node
// item (cmd 1) raises busy after its transfer for its steps: index reduction
// by the reciprocal multiplier, streak table read, then the nine compare
// lanes, the vote merge and the table write. The result strobe is registered
// from the last of these steps, and busy holds off a new node item until the
// streak table read-modify-write is done. The result cannot be stalled and
// is present for exactly one cycle. After reset the streak table is cleared
// one entry per cycle, with busy high; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
module node_free_space_streak_unit #(
    parameter int NODE_COUNT = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nfss_pkg::item_t                item,
    output logic                           result_valid,
    output nfss_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [nfss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nfss_pkg::DEPTH_W-1:0]   cfg_data
);

    import nfss_pkg::*;

    localparam int ADDR_W   = $clog2(NODE_COUNT);
    localparam int ENTRY_W  = EPOCH_W + STREAK_W;
    // ceil(2^32 / NODE_COUNT) gives the exact quotient for 16-bit ids
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 32) + 64'(NODE_COUNT) - 64'd1)
                                         / 64'(NODE_COUNT);
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [16:0] COUNT_K    = 17'(NODE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic [DEPTH_W-1:0]  tol_reg;
    logic [COUNT_W-1:0]  req_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    item_t               item_reg;
    logic [47:0]         quo_reg;
    logic [31:0]         prod_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]   idx_reg;

    logic                accept;
    logic [32:0]         rem_full;
    logic [DEPTH_W-1:0]  nbr [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] votes;
    verdict_t            verdict;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [EPOCH_W-1:0]  stored_epoch;
    logic [STREAK_W-1:0] old_streak;
    logic                consecutive;
    logic [STREAK_W-1:0] streak_next;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // remainder of the id after the registered reciprocal product
    assign rem_full = 33'(item_reg.node_id) - (33'(quo_reg[47:32]) * 33'(COUNT_K));

    // neighbour depths into the lanes
    assign nbr[0] = item_reg.depth_nw;
    assign nbr[1] = item_reg.depth_n;
    assign nbr[2] = item_reg.depth_ne;
    assign nbr[3] = item_reg.depth_w;
    assign nbr[4] = item_reg.depth_c;
    assign nbr[5] = item_reg.depth_e;
    assign nbr[6] = item_reg.depth_sw;
    assign nbr[7] = item_reg.depth_s;
    assign nbr[8] = item_reg.depth_se;

    for (genvar k = 0; k < NEIGHBOURS; k++)
    begin : g_lane
        nfss_lane u_lane (
            .depth (nbr[k]),
            .limit (limit_reg),
            .vote  (votes[k])
        );
    end

    nfss_merge u_merge (
        .votes            (votes),
        .support_required (req_reg),
        .verdict          (verdict)
    );

    // streak update from the table entry
    always_comb
    begin
        stored_epoch = ram_rdata[ENTRY_W-1:STREAK_W];
        old_streak   = ram_rdata[STREAK_W-1:0];
        consecutive  = ((stored_epoch + 32'd1) == epoch_reg);
        if (!verdict.is_free)
        begin
            streak_next = '0;
        end
        else if (!consecutive)
        begin
            streak_next = 16'd1;
        end
        else if (old_streak == STREAK_MAX)
        begin
            streak_next = STREAK_MAX;
        end
        else
        begin
            streak_next = old_streak + 16'd1;
        end
    end

    // table port control: clearing pass or write-back
    always_comb
    begin
        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_EVAL);
        ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : idx_reg;
        ram_wdata = (state_reg == S_CLEAR) ? '0 : {epoch_reg, streak_next};
        ram_re    = (state_reg == S_READ);
    end

    nfss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // sequencer, epoch, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            epoch_reg        <= '0;
            tol_reg          <= TOL_RESET;
            req_reg          <= SUPPORT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEPTH_TOLERANCE:  tol_reg <= cfg_data;
                    CFG_SUPPORT_REQUIRED: req_reg <= cfg_data[COUNT_W-1:0];
                    default:              ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.cmd == CMD_FRAME_TICK)
                        begin
                            epoch_reg <= epoch_reg + 32'd1;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg        <= S_IDLE;
                    result_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            quo_reg  <= 48'(item.node_id) * 48'(RECIP);
            prod_reg <= 32'(item.node_depth) * 32'(tol_reg);
        end
        if (state_reg == S_MOD)
        begin
            idx_reg   <= rem_full[ADDR_W-1:0];
            limit_reg <= {1'b0, item_reg.node_depth, 16'h0000} + LIMIT_W'(prod_reg);
        end
        if (state_reg == S_EVAL)
        begin
            result_reg.out_node_id   <= item_reg.node_id;
            result_reg.is_free       <= verdict.is_free;
            result_reg.support_count <= verdict.support_count;
            result_reg.streak_len    <= streak_next;
            result_reg.prune_ready   <= (streak_next >= DELETE_STREAK);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a result only follows the evaluation step
    a_result_after_eval: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_EVAL))
        else $error("result strobe without evaluation step");

    // a node transfer keeps the unit busy in the next cycle
    a_node_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (item.cmd == CMD_NODE)) |=> busy)
        else $error("node transfer did not raise busy");

    // a free node always carries a nonzero streak, a blocked one a zero streak
    a_streak_matches_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.is_free == (result.streak_len != '0)))
        else $error("streak disagrees with free flag");

    // no result while the table is being cleared
    a_no_result_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid)
        else $error("result during clearing pass");

endmodule

@@ bench/node_free_space_streak_unit_tb.sv @@
// ----------------------------------------------------------------------------
// node_free_space_streak_unit_tb
// Self-checking bench for the node free-space streak unit. A directed
// sequence covers the free-streak rules, zero node depth, invalid readings
// and the exact support threshold. Random frames then follow: each is a tick
// and a shuffled pool of recurring nodes, at times with a stray node after them.
// These run under several tolerance and vote settings, the extremes among
// them, with random gaps before each transfer. Each node transfer is predicted
// at its acceptance and checked field by field against the result strobe.
// ----------------------------------------------------------------------------
module node_free_space_streak_unit_tb;

    import nfss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 62;

    // streak predictor and store of pending node verdicts
    class streak_scoreboard;
        logic [DEPTH_W-1:0]  tolerance;
        logic [COUNT_W-1:0]  votes_needed;
        bit   [EPOCH_W-1:0]  frame_epoch;
        bit   [EPOCH_W-1:0]  seen_epoch [bit [ID_W-1:0]];
        bit   [STREAK_W-1:0] streak_of [bit [ID_W-1:0]];
        result_t             pending_verdicts [$];
        int                  errors;

        function new();
            tolerance    = TOL_RESET;
            votes_needed = SUPPORT_RESET;
            frame_epoch  = '0;
            errors       = 0;
        endfunction

        // predict the outcome of one accepted transfer
        function void note_item(item_t it);
            logic [DEPTH_W-1:0]  nbr [NEIGHBOURS];
            logic [33:0]         limit;
            logic [COUNT_W-1:0]  count;
            bit   [EPOCH_W-1:0]  last;
            bit   [STREAK_W-1:0] old_streak;
            bit   [STREAK_W-1:0] upd;
            bit                  free_now;
            result_t             want;
            if (it.cmd == CMD_FRAME_TICK)
            begin
                frame_epoch = frame_epoch + 1'b1;
                return;
            end
            nbr = '{it.depth_nw, it.depth_n, it.depth_ne, it.depth_w, it.depth_c,
                    it.depth_e, it.depth_sw, it.depth_s, it.depth_se};
            limit = 34'(it.node_depth) * (34'd65536 + 34'(tolerance));
            count = '0;
            foreach (nbr[k])
            begin
                if (nbr[k] != '0 && {2'b00, nbr[k], 16'h0000} > limit)
                    count = count + 1'b1;
            end
            free_now   = (count >= votes_needed);
            last       = seen_epoch.exists(it.node_id) ? seen_epoch[it.node_id] : '0;
            old_streak = streak_of.exists(it.node_id) ? streak_of[it.node_id] : '0;
            // streak grows only across back-to-back epochs
            if (!free_now)
                upd = '0;
            else if (last + 1'b1 == frame_epoch)
                upd = (old_streak == STREAK_MAX) ? STREAK_MAX : old_streak + 1'b1;
            else
                upd = 16'd1;
            streak_of[it.node_id]  = upd;
            seen_epoch[it.node_id] = frame_epoch;
            want.out_node_id   = it.node_id;
            want.is_free       = free_now;
            want.support_count = count;
            want.streak_len    = upd;
            want.prune_ready   = (upd >= DELETE_STREAK);
            pending_verdicts.insert(pending_verdicts.size(), want);
        endfunction

        function void check_field(string what, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        // compare a result strobe with the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual node %0d",
                         $time, got.out_node_id);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            check_field("out_node_id", want.out_node_id, got.out_node_id);
            check_field("is_free", want.is_free, got.is_free);
            check_field("support_count", want.support_count, got.support_count);
            check_field("streak_len", want.streak_len, got.streak_len);
            check_field("prune_ready", want.prune_ready, got.prune_ready);
        endfunction

        function void check_drained();
            if (pending_verdicts.size() != 0)
            begin
                $display("%0t: missing results, expected 0 pending actual %0d",
                         $time, pending_verdicts.size());
                errors += pending_verdicts.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    item_t                 item      = '0;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DEPTH_W-1:0]    cfg_data  = '0;

    streak_scoreboard      sb;
    logic [ID_W-1:0]       node_pool [$];
    int                    idle_pct;
    int                    cycles    = 0;

    node_free_space_streak_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: run limit reached", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // first neighbour depth that lies clearly behind the node, above 65535 if none
    function automatic int first_behind(logic [DEPTH_W-1:0] nd);
        longint lim;
        lim = longint'(nd) * (65536 + longint'(sb.tolerance));
        return int'(lim >> 16) + 1;
    endfunction

    function automatic logic [DEPTH_W-1:0] clamp_depth(int v);
        return (v > 65535) ? 16'hFFFF : ((v < 0) ? 16'h0000 : DEPTH_W'(v));
    endfunction

    // one neighbour reading: behind the node with the given odds, else zero, random or in front
    function automatic logic [DEPTH_W-1:0] pick_depth(logic [DEPTH_W-1:0] nd, int bias);
        int cut;
        cut = first_behind(nd);
        if ($urandom_range(0, 99) < bias)
            return ($urandom_range(0, 1) == 0) ? clamp_depth(cut)
                                               : clamp_depth(cut + $urandom_range(0, 2000));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DEPTH_W'($urandom_range(0, 65535));
            2: return clamp_depth(cut - 1);
            default: return clamp_depth($urandom_range(0, (cut > 65536) ? 65535 : cut - 1));
        endcase
    endfunction

    function automatic item_t build_node(logic [ID_W-1:0] id, logic [DEPTH_W-1:0] nd,
                                         logic [DEPTH_W-1:0] nbr [NEIGHBOURS]);
        item_t it;
        it.cmd        = CMD_NODE;
        it.node_id    = id;
        it.node_depth = nd;
        it.depth_nw   = nbr[0];
        it.depth_n    = nbr[1];
        it.depth_ne   = nbr[2];
        it.depth_w    = nbr[3];
        it.depth_c    = nbr[4];
        it.depth_e    = nbr[5];
        it.depth_sw   = nbr[6];
        it.depth_s    = nbr[7];
        it.depth_se   = nbr[8];
        return it;
    endfunction

    function automatic item_t random_node(logic [ID_W-1:0] id, int bias);
        logic [DEPTH_W-1:0] nd;
        logic [DEPTH_W-1:0] nbr [NEIGHBOURS];
        case ($urandom_range(0, 9))
            0: nd = '0;
            1: nd = DEPTH_W'($urandom_range(0, 65535));
            default: nd = DEPTH_W'($urandom_range(1, 30000));
        endcase
        foreach (nbr[k])
            nbr[k] = pick_depth(nd, bias);
        return build_node(id, nd, nbr);
    endfunction

    // frame tick with random content in the ignored fields
    function automatic item_t tick_item();
        item_t        it;
        logic [191:0] noise;
        noise  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it     = noise[$bits(item_t)-1:0];
        it.cmd = CMD_FRAME_TICK;
        return it;
    endfunction

    // one transfer: random gap, then hold start until busy is low at an edge
    task automatic send(item_t it);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending result, then let the pipeline drain
    task automatic settle();
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DEPTH_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEPTH_TOLERANCE)
            sb.tolerance = value;
        else
            sb.votes_needed = value[COUNT_W-1:0];
    endtask

    // directed checks under the reset settings
    task automatic run_directed();
        logic [DEPTH_W-1:0] behind;
        logic [DEPTH_W-1:0] front;
        idle_pct = 40;
        // free node before any tick, then streak across back-to-back epochs
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        send(tick_item());
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        send(tick_item());
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        // seen twice in one epoch restarts, then invalid readings clear
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        send(build_node(16'h0000, 16'd1000, '{9{16'd0}}));
        // zero node depth: every valid reading supports
        send(build_node(16'hFFFF, 16'd0, '{9{16'hFFFF}}));
        send(build_node(16'hFFFF, 16'd0, '{16'd0, 16'd1, 16'd0, 16'd1, 16'd0,
                                           16'd1, 16'd0, 16'd1, 16'd0}));
        // deepest node, nothing can be behind it
        send(build_node(16'h5A3C, 16'hFFFF, '{9{16'hFFFF}}));
        // exact threshold: just enough votes, then one short
        behind = clamp_depth(first_behind(16'd1000));
        front  = behind - 1'b1;
        send(build_node(16'h5A3C, 16'd1000, '{behind, front, behind, behind, front,
                                              behind, behind, front, behind}));
        send(build_node(16'h5A3C, 16'd1000, '{behind, front, behind, front, front,
                                              behind, behind, front, behind}));
        // skipped epoch restarts the streak
        send(tick_item());
        send(tick_item());
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        send(tick_item());
        send(build_node(16'h0000, 16'd1000, '{9{16'd3000}}));
        send(build_node(16'hA5C3, 16'd1000, '{9{16'd3000}}));
    endtask

    // random frames: tick, shuffled recurring nodes, at times a stray node
    task automatic run_frames(int budget);
        int sent;
        int bias;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 20;
                2: idle_pct = 60;
                default: idle_pct = 100;
            endcase
            send(tick_item());
            sent++;
            if ($urandom_range(0, 9) == 0)
            begin
                send(tick_item());
                sent++;
            end
            node_pool.shuffle();
            foreach (node_pool[i])
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    bias = ($urandom_range(0, 9) < 8) ? 90 : 15;
                    send(random_node(node_pool[i], bias));
                    sent++;
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                send(random_node(ID_W'($urandom_range(0, 65535)), $urandom_range(0, 100)));
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [DEPTH_W-1:0] tol_set [PHASES];
        logic [DEPTH_W-1:0] vote_set [PHASES];
        sb = new();
        repeat (6) node_pool.insert(node_pool.size(), ID_W'($urandom_range(0, 65535)));
        tol_set  = '{16'd0, 16'hFFFF, TOL_RESET, DEPTH_W'($urandom_range(0, 65535)),
                     16'hFFFF, 16'd0, DEPTH_W'($urandom_range(0, 65535))};
        vote_set = '{16'd0, 16'd9, 16'(SUPPORT_RESET), 16'd1, 16'd15,
                     DEPTH_W'($urandom_range(10, 15)), DEPTH_W'($urandom_range(1, 9))};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            go_idle();
            settle();
            write_register(CFG_DEPTH_TOLERANCE, tol_set[p]);
            write_register(CFG_SUPPORT_REQUIRED, vote_set[p]);
            run_frames(PHASE_ITEMS);
        end
        go_idle();
        settle();
        sb.check_drained();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ node_free_space_streak_unit.f @@
rtl/core/nfss_pkg.sv
rtl/core/nfss_ram.sv
rtl/core/nfss_lane.sv
rtl/core/nfss_merge.sv
rtl/core/node_free_space_streak_unit.sv
bench/node_free_space_streak_unit_tb.sv
